// ===== hdl/ogc_pkg.sv =====
`default_nettype none
package ogc_pkg;

  typedef struct packed {
    logic [24:0] cond;
    logic [24:0] mem;
    logic [38:0] acc;
  } ogc_entry_t;

  localparam logic [2:0] REG_PEAK   = 3'd0;
  localparam logic [2:0] REG_LIMIT  = 3'd1;
  localparam logic [2:0] REG_MAKEUP = 3'd2;
  localparam logic [2:0] REG_RATE   = 3'd3;
  localparam logic [2:0] REG_ATTACK = 3'd4;
  localparam logic [2:0] REG_SLOW   = 3'd5;
  localparam logic [2:0] REG_STEP   = 3'd6;

  localparam logic XL_LOG2 = 1'b0;
  localparam logic XL_EXP2 = 1'b1;

  typedef struct packed {
    logic        start;
    logic        op;
    logic [63:0] larg;
    logic [31:0] earg;
  } ogc_xl_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } ogc_xl_resp_t;

  typedef struct packed {
    logic        start;
    logic [56:0] num;
    logic [43:0] den;
  } ogc_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } ogc_div_resp_t;

  localparam logic [30:0] POW2_FRAC [16] = '{
    31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
    31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
    31'd1075196443, 31'd1074468887, 31'd1074105294, 31'd1073923544,
    31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753180
  };

  localparam logic [24:0] ONE_Q24    = 25'h100_0000;
  localparam logic [38:0] ACC_ONE    = 39'h01_0000_0000;
  localparam logic [38:0] ACC_MAX    = 39'h40_0000_0000;
  localparam logic [25:0] TAU_BASE   = 26'd1006633;
  localparam logic [16:0] P_COMP     = 17'd39322;
  localparam logic [16:0] P_LIMIT    = 17'd98304;
  localparam logic [16:0] P_REL      = 17'd42598;
  localparam logic [12:0] DRV_SLOPE  = 13'd4354;
  localparam logic [21:0] DB_TO_LOG2 = 22'd2786635;
  localparam logic [31:0] RECIP6     = 32'hAAAA_AAAB;
  localparam logic [31:0] EXP_MIN    = 32'hFFD8_0000;
  localparam logic [31:0] EXP_MAX    = 32'h001E_0000;
  localparam logic [22:0] EXP_BIAS   = 23'h28_0000;
  localparam logic [6:0]  EXP_SH0    = 7'd38;
  localparam logic [23:0] LOG_ZERO   = 24'hC0_0000;

  localparam logic [6:0]  RST_PEAK   = 7'd0;
  localparam logic [17:0] RST_RATE   = 18'd48000;
  localparam logic [31:0] RST_ATTACK = 32'd8938725;
  localparam logic [31:0] RST_SLOW   = 32'd44739;
  localparam logic [31:0] RST_STEP   = 32'd17895;

endpackage
`default_nettype wire

// ===== hdl/ogc_ram.sv =====
`default_nettype none
module ogc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                    wdata,
  input  wire logic                                re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    if (re) begin
      rdata <= store[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ogc_div.sv =====
`default_nettype none
module ogc_div
  import ogc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ogc_div_req_t  req,
  output ogc_div_resp_t      resp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [43:0] rem;
  logic [43:0] den;
  logic [31:0] lo;
  logic [31:0] q;
  logic [44:0] r2;
  logic        fits;

  assign r2   = {rem, lo[31]};
  assign fits = r2 >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
    if (req.start) begin
      rem <= {19'd0, req.num[56:32]};
      lo  <= req.num[31:0];
      den <= req.den;
      cnt <= 5'd0;
    end else if (busy) begin
      rem <= fits ? 44'(r2 - {1'b0, den}) : r2[43:0];
      q   <= {q[30:0], fits};
      lo  <= {lo[30:0], 1'b0};
      cnt <= cnt + 5'd1;
    end
  end

  assign resp.done = done;
  assign resp.quot = q;

endmodule
`default_nettype wire

// ===== hdl/ogc_explog.sv =====
`default_nettype none
module ogc_explog
  import ogc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire ogc_xl_req_t  req,
  output ogc_xl_resp_t      resp
);

  localparam logic [1:0] XS_IDLE = 2'd0;
  localparam logic [1:0] XS_NORM = 2'd1;
  localparam logic [1:0] XS_ITER = 2'd2;
  localparam logic [1:0] XS_FIN  = 2'd3;

  logic [1:0]  st;
  logic        op;
  logic        zero;
  logic [63:0] v;
  logic [5:0]  p;
  logic [31:0] m;
  logic [15:0] fr;
  logic [15:0] f;
  logic [3:0]  k;
  logic [6:0]  ipc;

  logic [31:0] mb;
  logic [63:0] sq;
  logic [31:0] t;
  logic [31:0] xc;
  logic [22:0] xu;
  logic [6:0]  p7;
  logic [23:0] lres;
  logic [63:0] eres;

  assign mb = (op == XL_LOG2) ? m : {1'b0, POW2_FRAC[k]};
  assign sq = m * mb;
  assign t  = sq[61:30];

  always_comb begin
    if ($signed(req.earg) < $signed(EXP_MIN)) begin
      xc = EXP_MIN;
    end else if ($signed(req.earg) > $signed(EXP_MAX)) begin
      xc = EXP_MAX;
    end else begin
      xc = req.earg;
    end
  end
  assign xu = 23'(xc + 32'(EXP_BIAS));

  assign p7   = {1'b0, p} - 7'd32;
  assign lres = zero ? LOG_ZERO : {p7[6], p7, fr};
  assign eres = (ipc >= EXP_SH0) ? ({32'd0, m} << (ipc - EXP_SH0))
                                 : ({32'd0, m} >> (EXP_SH0 - ipc));

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= XS_IDLE;
    end else begin
      unique case (st)
        XS_IDLE: begin
          if (req.start) begin
            op   <= req.op;
            k    <= 4'd0;
            fr   <= 16'd0;
            zero <= 1'b0;
            m    <= 32'h4000_0000;
            if (req.op == XL_LOG2) begin
              v <= req.larg;
              p <= 6'd63;
              if (req.larg == 64'd0) begin
                zero <= 1'b1;
                st   <= XS_FIN;
              end else begin
                st <= XS_NORM;
              end
            end else begin
              f   <= xu[15:0];
              ipc <= xu[22:16];
              st  <= XS_ITER;
            end
          end
        end
        XS_NORM: begin
          if (v[63]) begin
            m  <= {1'b0, v[63:33]};
            st <= XS_ITER;
          end else if (v[63:56] == 8'd0) begin
            v <= {v[55:0], 8'd0};
            p <= p - 6'd8;
          end else begin
            v <= {v[62:0], 1'b0};
            p <= p - 6'd1;
          end
        end
        XS_ITER: begin
          if (op == XL_LOG2) begin
            if (t[31]) begin
              m <= {1'b0, t[31:1]};
              fr[4'd15 - k] <= 1'b1;
            end else begin
              m <= t;
            end
          end else if (f[4'd15 - k]) begin
            m <= t;
          end
          k <= k + 4'd1;
          if (k == 4'd15) begin
            st <= XS_FIN;
          end
        end
        XS_FIN: begin
          st <= XS_IDLE;
        end
        default: begin
          st <= XS_IDLE;
        end
      endcase
    end
  end

  assign resp.done   = (st == XS_FIN);
  assign resp.result = (op == XL_LOG2) ? {{40{lres[23]}}, lres} : eres;

endmodule
`default_nettype wire

// ===== hdl/opto_gain_cell_step_core.sv =====
`default_nettype none
// Optical gain cell, one audio sample per beat. Each beat runs to completion before the
// next is taken, and a beat that releases takes longer than one that attacks. The time is
// set by the shared 16-step log2/exp2 unit (one squaring or one table product per cycle)
// and, on release, by up to two passes of the one-bit-per-cycle divider.
// Per-channel conductance, memory and release accumulator sit in one small RAM read and
// written once per beat; entries never written read as their reset values, so no clearing
// pass follows reset. A result waiting on the output does not block taking the next input beat.
module opto_gain_cell_step_core
  import ogc_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               channel_index,
  input  wire logic [15:0]        detector_level,
  input  wire logic signed [23:0] audio_sample,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_channel,
  output logic signed [13:0]      reduction_db,
  output logic signed [23:0]      gained_sample
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EW = $bits(ogc_entry_t);

  localparam logic [5:0] S_IDLE     = 6'd0;
  localparam logic [5:0] S_RD       = 6'd1;
  localparam logic [5:0] S_W_DRV    = 6'd2;
  localparam logic [5:0] S_DRV_LO   = 6'd3;
  localparam logic [5:0] S_DRV_HI   = 6'd4;
  localparam logic [5:0] S_DRV_SUM  = 6'd5;
  localparam logic [5:0] S_W_LOGG   = 6'd6;
  localparam logic [5:0] S_POWG_MUL = 6'd7;
  localparam logic [5:0] S_POWG_EXP = 6'd8;
  localparam logic [5:0] S_W_EXPG   = 6'd9;
  localparam logic [5:0] S_DECIDE   = 6'd10;
  localparam logic [5:0] S_ATT_UPD  = 6'd11;
  localparam logic [5:0] S_REL_N    = 6'd12;
  localparam logic [5:0] S_W_DIVX   = 6'd13;
  localparam logic [5:0] S_X2       = 6'd14;
  localparam logic [5:0] S_X3       = 6'd15;
  localparam logic [5:0] S_X6       = 6'd16;
  localparam logic [5:0] S_XA       = 6'd17;
  localparam logic [5:0] S_W_LOGA   = 6'd18;
  localparam logic [5:0] S_POWA     = 6'd19;
  localparam logic [5:0] S_POWA_E   = 6'd20;
  localparam logic [5:0] S_W_EXPA   = 6'd21;
  localparam logic [5:0] S_DIVA_GO  = 6'd22;
  localparam logic [5:0] S_W_DIVA   = 6'd23;
  localparam logic [5:0] S_RMUL     = 6'd24;
  localparam logic [5:0] S_RUPD     = 6'd25;
  localparam logic [5:0] S_CLAMP    = 6'd26;
  localparam logic [5:0] S_MEMUPD   = 6'd27;
  localparam logic [5:0] S_WB       = 6'd28;
  localparam logic [5:0] S_GR       = 6'd29;
  localparam logic [5:0] S_GE       = 6'd30;
  localparam logic [5:0] S_W_EXPE   = 6'd31;
  localparam logic [5:0] S_GMUL     = 6'd32;
  localparam logic [5:0] S_FIN      = 6'd33;

  // configuration
  logic [6:0]  peak_reduction;
  logic        limit_mode;
  logic [14:0] makeup_gain_db;
  logic [17:0] sample_rate;
  logic [31:0] attack_coeff;
  logic [31:0] slow_coeff;
  logic [31:0] accum_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_reduction <= RST_PEAK;
      limit_mode     <= 1'b0;
      makeup_gain_db <= 15'd0;
      sample_rate    <= RST_RATE;
      attack_coeff   <= RST_ATTACK;
      slow_coeff     <= RST_SLOW;
      accum_step     <= RST_STEP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PEAK:   peak_reduction <= cfg_data[6:0];
        REG_LIMIT:  limit_mode     <= cfg_data[0];
        REG_MAKEUP: makeup_gain_db <= cfg_data[14:0];
        REG_RATE:   sample_rate    <= cfg_data[17:0];
        REG_ATTACK: attack_coeff   <= cfg_data;
        REG_SLOW:   slow_coeff     <= cfg_data;
        REG_STEP:   accum_step     <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state and working registers
  logic [5:0]         state;
  logic [AW-1:0]      ix;
  logic               ch;
  logic [15:0]        level;
  logic signed [23:0] smp;
  logic [24:0]        cond;
  logic [24:0]        mem;
  logic [38:0]        acc;
  logic [37:0]        drive;
  logic [47:0]        t0;
  logic [23:0]        lg;
  logic [24:0]        g;
  logic [31:0]        x;
  logic [31:0]        x2;
  logic [31:0]        alpha;
  logic [43:0]        pm;
  logic [12:0]        gr;
  logic [34:0]        gain;
  logic               mem_up;
  logic [CHANNELS-1:0] ent_valid;

  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [68:0] prod;
  logic [67:0]        pu;

  ogc_xl_req_t   xl_req;
  ogc_xl_resp_t  xl_resp;
  ogc_div_req_t  div_req;
  ogc_div_resp_t div_resp;

  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ix_in;
  logic [EW-1:0]      ram_rdata;
  ogc_entry_t         rd_ent;
  ogc_entry_t         wr_ent;

  // combinational helpers
  logic signed [8:0]  pr_off;
  logic signed [31:0] drv_x;
  logic signed [68:0] tq;
  logic [31:0]        trunc_e;
  logic [63:0]        drv_full;
  logic [63:0]        gcap;
  logic [39:0]        acc_sum;
  logic [38:0]        acc_sat;
  logic [25:0]        tau;
  logic [24:0]        cond_c;
  logic               cond_ge;
  logic [24:0]        diffm;
  logic [67:0]        rnd32;
  logic [67:0]        rnd16;
  logic [67:0]        rnd24;
  logic [33:0]        alpha_c;
  logic [43:0]        pm_raw;
  logic signed [15:0] total_db;
  logic [23:0]        mag;
  logic [34:0]        r_c;
  logic signed [23:0] res_c;

  assign ix_in = (32'(channel_index) < CHANNELS) ? AW'(channel_index) : AW'(CHANNELS - 1);
  assign in_stall = (state != S_IDLE);
  assign pu = prod[67:0];

  assign pr_off   = $signed({2'b00, peak_reduction}) - 9'sd50;
  assign drv_x    = 32'(pr_off * $signed({1'b0, DRV_SLOPE}));
  assign tq       = prod + (prod[68] ? 69'sd65535 : 69'sd0);
  assign trunc_e  = tq[47:16];
  assign drv_full = {pu[31:0], 32'd0} + {16'd0, t0};
  assign gcap     = (xl_resp.result > 64'h1_0000_0000) ? 64'h1_0000_0000 : xl_resp.result;
  assign acc_sum  = {1'b0, acc} + {8'd0, accum_step};
  assign acc_sat  = (acc_sum > {1'b0, ACC_MAX}) ? ACC_MAX : acc_sum[38:0];
  assign tau      = TAU_BASE + {1'b0, mem} + {2'b00, mem[24:1]};
  assign cond_c   = (cond > ONE_Q24) ? ONE_Q24 : cond;
  assign cond_ge  = cond_c >= mem;
  assign diffm    = cond_ge ? (cond_c - mem) : (mem - cond_c);
  assign rnd32    = pu + 68'h8000_0000;
  assign rnd16    = pu + 68'h8000;
  assign rnd24    = pu + 68'h80_0000;
  assign alpha_c  = {2'b00, x} - {3'b000, x2[31:1]} + {2'b00, pu[65:34]};
  assign pm_raw   = xl_resp.result[59:16];
  assign total_db = $signed({makeup_gain_db[14], makeup_gain_db})
                  - $signed({3'b000, rnd16[28:16]});
  assign mag      = smp[23] ? 24'(-smp) : 24'(smp);
  assign r_c      = rnd24[58:24];

  always_comb begin
    if (smp[23]) begin
      res_c = (r_c > 35'h80_0000) ? 24'sh80_0000 : 24'(-$signed({1'b0, r_c}));
    end else begin
      res_c = (r_c > 35'h7F_FFFF) ? 24'sh7F_FFFF : 24'(r_c);
    end
  end

  // shared multiplier, operands chosen by sequencer step
  always_comb begin
    mul_a = 36'sd0;
    mul_b = 33'sd0;
    unique case (state)
      S_DRV_LO: begin
        mul_a = $signed(36'(drive[31:0]));
        mul_b = $signed(33'(level));
      end
      S_DRV_HI: begin
        mul_a = $signed(36'(drive[37:32]));
        mul_b = $signed(33'(level));
      end
      S_POWG_MUL: begin
        mul_a = 36'($signed(lg));
        mul_b = $signed(33'(limit_mode ? P_LIMIT : P_COMP));
      end
      S_DECIDE: begin
        if (g > cond) begin
          mul_a = $signed(36'(g - cond));
          mul_b = $signed(33'(attack_coeff));
        end else begin
          mul_a = $signed(36'(tau));
          mul_b = $signed(33'(sample_rate));
        end
      end
      S_X2: begin
        mul_a = $signed(36'(x));
        mul_b = $signed(33'(x));
      end
      S_X3: begin
        mul_a = $signed(36'(pu[63:32]));
        mul_b = $signed(33'(x));
      end
      S_X6: begin
        mul_a = $signed(36'(pu[63:32]));
        mul_b = $signed(33'(RECIP6));
      end
      S_POWA: begin
        mul_a = 36'($signed(lg));
        mul_b = $signed(33'(P_REL));
      end
      S_RMUL: begin
        mul_a = $signed(36'(cond - g));
        mul_b = $signed(33'(alpha));
      end
      S_CLAMP: begin
        mul_a = $signed(36'(diffm));
        mul_b = $signed(33'(slow_coeff));
      end
      S_WB: begin
        mul_a = $signed(36'(cond));
        mul_b = limit_mode ? 33'sd30 : 33'sd15;
      end
      S_GR: begin
        mul_a = 36'(total_db);
        mul_b = $signed(33'(DB_TO_LOG2));
      end
      S_GMUL: begin
        mul_a = $signed(36'(gain));
        mul_b = $signed(33'(mag));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // log2 / exp2 unit requests
  always_comb begin
    xl_req.start = (state == S_RD) || (state == S_DRV_SUM) || (state == S_POWG_EXP)
                || (state == S_XA) || (state == S_POWA_E) || (state == S_GE);
    xl_req.op    = ((state == S_DRV_SUM) || (state == S_XA)) ? XL_LOG2 : XL_EXP2;
    xl_req.larg  = (state == S_DRV_SUM) ? (drv_full >> 14) : {25'd0, acc};
    xl_req.earg  = (state == S_RD) ? drv_x : trunc_e;
  end

  ogc_explog u_explog (
    .clk  (clk),
    .rst  (rst),
    .req  (xl_req),
    .resp (xl_resp)
  );

  always_comb begin
    div_req.start = ((state == S_REL_N) && (pu > 68'(ONE_Q24))) || (state == S_DIVA_GO);
    div_req.num   = (state == S_REL_N) ? (57'd1 << 56) : {9'd0, alpha, 16'd0};
    div_req.den   = (state == S_REL_N) ? pu[43:0] : pm;
  end

  ogc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  // per-channel state memory
  assign ram_re = (state == S_IDLE) && in_valid;
  assign ram_we = (state == S_WB);
  assign rd_ent = ogc_entry_t'(ram_rdata);
  assign wr_ent = '{cond: cond, mem: mem, acc: acc};

  ogc_ram #(
    .WIDTH (EW),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ix),
    .wdata (wr_ent),
    .re    (ram_re),
    .raddr (ix_in),
    .rdata (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ent_valid <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            ch    <= channel_index;
            ix    <= ix_in;
            level <= detector_level;
            smp   <= audio_sample;
            state <= S_RD;
          end
        end
        S_RD: begin
          if (ent_valid[ix]) begin
            cond <= rd_ent.cond;
            mem  <= rd_ent.mem;
            acc  <= rd_ent.acc;
          end else begin
            cond <= 25'd0;
            mem  <= 25'd0;
            acc  <= ACC_ONE;
          end
          state <= S_W_DRV;
        end
        S_W_DRV: begin
          if (xl_resp.done) begin
            drive <= xl_resp.result[37:0];
            state <= S_DRV_LO;
          end
        end
        S_DRV_LO:   state <= S_DRV_HI;
        S_DRV_HI: begin
          t0    <= pu[47:0];
          state <= S_DRV_SUM;
        end
        S_DRV_SUM:  state <= S_W_LOGG;
        S_W_LOGG: begin
          if (xl_resp.done) begin
            lg    <= xl_resp.result[23:0];
            state <= S_POWG_MUL;
          end
        end
        S_POWG_MUL: state <= S_POWG_EXP;
        S_POWG_EXP: state <= S_W_EXPG;
        S_W_EXPG: begin
          if (xl_resp.done) begin
            g     <= gcap[32:8];
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (g > cond) begin
            state <= S_ATT_UPD;
          end else begin
            acc   <= acc_sat;
            state <= S_REL_N;
          end
        end
        S_ATT_UPD: begin
          cond  <= cond + rnd32[56:32];
          acc   <= ACC_ONE;
          state <= S_CLAMP;
        end
        S_REL_N: begin
          if (pu > 68'(ONE_Q24)) begin
            state <= S_W_DIVX;
          end else begin
            x     <= 32'hFFFF_FFFF;
            state <= S_X2;
          end
        end
        S_W_DIVX: begin
          if (div_resp.done) begin
            x     <= div_resp.quot;
            state <= S_X2;
          end
        end
        S_X2:       state <= S_X3;
        S_X3: begin
          x2    <= pu[63:32];
          state <= S_X6;
        end
        S_X6:       state <= S_XA;
        S_XA: begin
          alpha <= alpha_c[31:0];
          state <= S_W_LOGA;
        end
        S_W_LOGA: begin
          if (xl_resp.done) begin
            lg    <= xl_resp.result[23:0];
            state <= S_POWA;
          end
        end
        S_POWA:     state <= S_POWA_E;
        S_POWA_E:   state <= S_W_EXPA;
        S_W_EXPA: begin
          if (xl_resp.done) begin
            pm    <= (pm_raw < 44'h1_0000) ? 44'h1_0000 : pm_raw;
            state <= S_DIVA_GO;
          end
        end
        S_DIVA_GO:  state <= S_W_DIVA;
        S_W_DIVA: begin
          if (div_resp.done) begin
            alpha <= div_resp.quot;
            state <= S_RMUL;
          end
        end
        S_RMUL:     state <= S_RUPD;
        S_RUPD: begin
          cond  <= cond - rnd32[56:32];
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          cond   <= cond_c;
          mem_up <= cond_ge;
          state  <= S_MEMUPD;
        end
        S_MEMUPD: begin
          mem   <= mem_up ? (mem + rnd32[56:32]) : (mem - rnd32[56:32]);
          state <= S_WB;
        end
        S_WB: begin
          ent_valid[ix] <= 1'b1;
          state         <= S_GR;
        end
        S_GR: begin
          gr    <= rnd16[28:16];
          state <= S_GE;
        end
        S_GE:       state <= S_W_EXPE;
        S_W_EXPE: begin
          if (xl_resp.done) begin
            gain  <= xl_resp.result[42:8];
            state <= S_GMUL;
          end
        end
        S_GMUL:     state <= S_FIN;
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            out_channel   <= ch;
            reduction_db  <= 14'(-$signed({1'b0, gr}));
            gained_sample <= res_c;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_xl_done_waited: assert property (@(posedge clk) disable iff (rst)
    xl_resp.done |-> (state == S_W_DRV || state == S_W_LOGG || state == S_W_EXPG ||
                      state == S_W_LOGA || state == S_W_EXPA || state == S_W_EXPE))
    else $error("log/exp result with no step waiting on it");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_resp.done |-> (state == S_W_DIVX || state == S_W_DIVA))
    else $error("divider result with no step waiting on it");

  a_wb_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (wr_ent.cond <= ONE_Q24 && wr_ent.mem <= ONE_Q24 && wr_ent.acc <= ACC_MAX))
    else $error("state write out of range");

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_RD))
    else $error("accepted beat did not start a state read");

endmodule
`default_nettype wire
